// ===== rtl/core/shuffled_lehmer_random_assert.svh =====
// assertion macros for the shuffled lehmer random generator
`ifndef SHUFFLED_LEHMER_RANDOM_ASSERT_SVH
`define SHUFFLED_LEHMER_RANDOM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SLR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/slr_pkg.sv =====
// package: constants, types and control structs of the shuffled lehmer generator
package slr_pkg;

  localparam int TABLE_SIZE   = 32;
  localparam int WARMUP_STEPS = 8;
  localparam int LOAD_STEPS   = TABLE_SIZE + WARMUP_STEPS;
  localparam int TBL_AW       = $clog2(TABLE_SIZE);
  localparam int CNT_W        = $clog2(LOAD_STEPS);

  localparam int VAL_W  = 31;
  localparam int MULT_W = 15;
  localparam int PROD_W = VAL_W + MULT_W;

  localparam logic [MULT_W-1:0] LEHMER_MULT = MULT_W'(16807);
  localparam logic [VAL_W-1:0]  LEHMER_MOD  = {VAL_W{1'b1}};

  // slot = held / (1 + (mod - 1) / size), a power of two for power-of-two sizes
  localparam longint SLOT_DIV   = 1 + (longint'(LEHMER_MOD) - 1) / TABLE_SIZE;
  localparam int     SLOT_SHIFT = $clog2(SLOT_DIV);

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [TBL_AW-1:0] tbl_addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED
  } slr_state_t;

  typedef struct packed {
    logic      load_init;
    logic      use_input;
    logic      mul;
    logic      reduce;
    logic      load_wr;
    tbl_addr_t load_addr;
    logic      load_last;
    logic      draw_read;
    logic      draw_fire;
  } slr_cmd_t;

  typedef struct packed {
    logic held_zero;
    logic out_free;
  } slr_status_t;

endpackage

// ===== rtl/core/slr_req_if.sv =====
// request channel: valid/ready with mode and seed magnitude
interface slr_req_if;
  import slr_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  val_t seed_magnitude;

  modport source (output valid, output mode, output seed_magnitude, input ready);
  modport sink (input valid, input mode, input seed_magnitude, output ready);
endinterface

// ===== rtl/core/slr_rsp_if.sv =====
// response channel: valid/ready with the random value
interface slr_rsp_if;
  import slr_pkg::*;
  logic valid;
  logic ready;
  val_t random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// ===== rtl/core/slr_ram.sv =====
// generic single-write ram with registered read
module slr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/slr_ctrl.sv =====
// controller: sequences table load and draw steps
module slr_ctrl
  import slr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_mode,
  output logic        in_ready,
  input  slr_status_t status,
  output slr_cmd_t    cmd
);

  slr_state_t state, state_next;
  cnt_t       cnt, cnt_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.use_input = in_mode;
    cmd.load_addr = cnt[TBL_AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode || status.held_zero) begin
            cmd.load_init = 1'b1;
            cnt_next      = CNT_W'(LOAD_STEPS - 1);
            state_next    = ST_LOAD_MUL;
          end else begin
            state_next = ST_DRAW_MUL;
          end
        end
      end
      ST_LOAD_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_LOAD_RED;
      end
      ST_LOAD_RED: begin
        cmd.reduce  = 1'b1;
        cmd.load_wr = ({1'b0, cnt} < (CNT_W + 1)'(TABLE_SIZE));
        if (cnt == '0) begin
          cmd.load_last = 1'b1;
          state_next    = ST_DRAW_MUL;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = ST_LOAD_MUL;
        end
      end
      ST_DRAW_MUL: begin
        cmd.mul       = 1'b1;
        cmd.draw_read = 1'b1;
        state_next    = ST_DRAW_RED;
      end
      ST_DRAW_RED: begin
        if (status.out_free) begin
          cmd.reduce    = 1'b1;
          cmd.draw_fire = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/slr_dpath.sv =====
// datapath: lehmer multiply and fold, shuffle table, held value and output register
module slr_dpath
  import slr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  slr_cmd_t    cmd,
  input  val_t        seed_magnitude,
  input  logic        out_ready,
  output logic        out_valid,
  output val_t        out_data,
  output slr_status_t status
);

  val_t            seed;
  val_t            held;
  prod_t           prod;
  val_t            sanitized;
  logic [VAL_W:0]  fold_sum;
  val_t            folded;
  tbl_addr_t       slot;
  logic            ram_we;
  tbl_addr_t       ram_waddr;
  val_t            ram_rdata;

  assign sanitized = (seed_magnitude == '0 || seed_magnitude == LEHMER_MOD)
                     ? VAL_W'(1) : seed_magnitude;

  // p mod (2^31 - 1) = high part + low part, one conditional subtract
  assign fold_sum = {1'b0, prod[VAL_W-1:0]} + (VAL_W + 1)'(prod[PROD_W-1:VAL_W]);
  assign folded   = (fold_sum >= {1'b0, LEHMER_MOD})
                    ? VAL_W'(fold_sum - {1'b0, LEHMER_MOD}) : fold_sum[VAL_W-1:0];

  assign slot = held[VAL_W-1:SLOT_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(seed) * PROD_W'(LEHMER_MULT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= VAL_W'(1);
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_init) begin
        seed <= cmd.use_input ? sanitized : VAL_W'(1);
      end else if (cmd.reduce) begin
        seed <= folded;
      end
      if (cmd.load_last) begin
        held <= folded;
      end else if (cmd.draw_fire) begin
        held <= ram_rdata;
      end
      if (cmd.draw_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_fire) begin
      out_data <= ram_rdata;
    end
  end

  assign ram_we    = cmd.load_wr || cmd.draw_fire;
  assign ram_waddr = cmd.draw_fire ? slot : cmd.load_addr;

  slr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (folded),
    .re    (cmd.draw_read),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign status.held_zero = (held == '0);
  assign status.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/core/shuffled_lehmer_random.sv =====
// top level: shuffled lehmer random generator
//
//   channel  role   handshake      payload
//   req      sink   valid/ready    mode, seed_magnitude
//   rsp      source valid/ready    random_value
//
// a draw from a loaded table: rsp valid is registered after the multiply and fold states
// req is accepted only in idle: a new req waits for the multiply and fold of the last one
// a reseed, or the first draw after reset, adds 40 lehmer steps, each a multiply and a fold
// each lehmer step is one registered 31x15 multiply followed by one fold and subtract
// rst is synchronous; seed resets to 1 and held value to 0 (table not loaded)
// a stalled rsp holds the last fold until the output register frees; req waits meanwhile
module shuffled_lehmer_random
  import slr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  slr_req_if.sink req,
  slr_rsp_if.source rsp
);

  slr_cmd_t    cmd;
  slr_status_t status;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  slr_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .seed_magnitude (req.seed_magnitude),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_data       (rsp.random_value),
    .status         (status)
  );

endmodule

// ===== rtl/core/slr_checker.sv =====
// port-level checker for the shuffled lehmer generator, bound to the top level
`include "shuffled_lehmer_random_assert.svh"

module slr_checker
  import slr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input val_t rsp_value
);

  `SLR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value), "rsp beat changed while stalled")
  `SLR_ASSERT_NOW(a_rsp_range, clk, rst, rsp_valid, rsp_value != '0 && rsp_value != LEHMER_MOD, "rsp value outside 1 to modulus minus 1")
  `SLR_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "req ready the cycle after an accepted beat")
  `SLR_ASSERT_NEXT(a_no_early_rsp, clk, rst, req_valid && req_ready && (!rsp_valid || rsp_ready), !rsp_valid, "rsp beat one cycle after accept")

endmodule

bind shuffled_lehmer_random slr_checker u_slr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.random_value)
);

// ===== bench/shuffled_lehmer_random_tb.sv =====
// testbench: shuffled lehmer generator checked beat by beat against a local predictor
`timescale 1ns / 100ps

module shuffled_lehmer_random_tb;
  import slr_pkg::*;

  localparam int NUM_RANDOM = 1200;
  localparam int TAIL_ITEMS = 150;

  class shuffle_predictor;
    val_t   seed_state;
    val_t   held_value;
    val_t   slots[TABLE_SIZE];
    val_t   expected_values[$];
    int     errors;
    int     checked;

    function new();
      seed_state = val_t'(1);
      held_value = '0;
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function val_t lehmer_step(val_t s);
      longint unsigned prod;
      prod = longint'(s) * 64'd16807;
      return val_t'(prod % 64'd2147483647);
    endfunction

    function void fill_slots(val_t start);
      val_t s;
      s = start;
      for (int n = TABLE_SIZE + WARMUP_STEPS - 1; n >= 0; n--) begin
        s = lehmer_step(s);
        if (n < TABLE_SIZE) slots[n] = s;
      end
      seed_state = s;
      held_value = slots[0];
    endfunction

    function void note_request(logic reseed, val_t magnitude);
      val_t   start;
      longint unsigned idx;
      if (reseed) begin
        start = (magnitude == '0 || magnitude == LEHMER_MOD) ? val_t'(1) : magnitude;
        fill_slots(start);
      end else if (held_value == '0) begin
        fill_slots(val_t'(1));
      end
      seed_state = lehmer_step(seed_state);
      idx = longint'(held_value) / SLOT_DIV;
      if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
      held_value = slots[idx];
      slots[idx] = seed_state;
      expected_values.push_back(held_value);
    endfunction

    task check_value(val_t got);
      val_t want;
      checked++;
      if (expected_values.size() == 0) begin
        report($sformatf("random_value %0d with nothing expected", got));
        return;
      end
      want = expected_values.pop_front();
      if (got !== want)
        report($sformatf("random_value got %0d expected %0d (beat %0d)", got, want, checked));
    endtask
  endclass

  logic clk;
  logic rst;
  slr_req_if req_ch();
  slr_rsp_if rsp_ch();

  shuffled_lehmer_random u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  shuffle_predictor sb = new();
  bit quiet_tail;
  bit calm_phase;
  int draws_sent;
  int reseeds_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout: %0d results still outstanding", sb.expected_values.size());
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_value(rsp_ch.random_value);
  end

  // sink side back-pressure
  initial begin
    int burst;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && !calm_phase && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 7);
        rsp_ch.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic reseed, val_t magnitude);
    int gap;
    gap = 0;
    if (!quiet_tail && !calm_phase && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= reseed;
    req_ch.seed_magnitude <= magnitude;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(reseed, magnitude);
    if (reseed) reseeds_sent++;
    else draws_sent++;
  endtask

  function automatic val_t pick_seed();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return LEHMER_MOD;
      2: return LEHMER_MOD - 1;
      3: return val_t'(1) << $urandom_range(0, VAL_W - 1);
      default: return val_t'($urandom());
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = 1'b0;
    req_ch.seed_magnitude = '0;
    quiet_tail = 1'b0;
    calm_phase = 1'b0;
    draws_sent = 0;
    reseeds_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // draw straight after reset loads the table from seed 1
    send_item(1'b0, val_t'($urandom()));
    send_item(1'b0, '1);
    send_item(1'b0, '0);
    send_item(1'b1, '0);
    send_item(1'b0, '0);
    send_item(1'b1, LEHMER_MOD);
    send_item(1'b0, '1);
    send_item(1'b1, LEHMER_MOD - 1);
    send_item(1'b0, '0);
    send_item(1'b1, val_t'(1));
    send_item(1'b1, val_t'(2));
    send_item(1'b1, val_t'(31'h4000_0000));
    send_item(1'b1, val_t'(31'h2AAA_AAAA));
    send_item(1'b1, val_t'(31'h5555_5555));
    repeat (8) send_item(1'b0, val_t'($urandom()));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 100 == 0) calm_phase = ($urandom_range(0, 4) == 0);
      if (i == NUM_RANDOM - TAIL_ITEMS) begin
        quiet_tail = 1'b1;
        calm_phase = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) send_item(1'b1, pick_seed());
      else send_item(1'b0, val_t'($urandom()));
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (sb.expected_values.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("covered %0d draws and %0d reseeds, including zero and modulus seeds",
             draws_sent, reseeds_sent);
    $display("checked %0d result beats under random stalls, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_values.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.expected_values.size() != 0)
        $display("%0d expected results never arrived", sb.expected_values.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/slr_pkg.sv
rtl/core/slr_req_if.sv
rtl/core/slr_rsp_if.sv
rtl/core/slr_ram.sv
rtl/core/slr_ctrl.sv
rtl/core/slr_dpath.sv
rtl/core/shuffled_lehmer_random.sv
rtl/core/slr_checker.sv
bench/shuffled_lehmer_random_tb.sv
